>>> rtl/asc_pkg.sv
package asc_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_AD    = 2'd1,
    OP_MSG   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AD   = 2'd1,
    PH_MSG  = 2'd2,
    PH_RSV  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_DECRYPT  = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2,
    ST_TAG  = 2'd3
  } eng_state_t;

  // step applied to the state after a permutation ends
  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_KEY  = 2'd1,
    POST_DSEP = 2'd2,
    POST_RSV  = 2'd3
  } post_t;

  localparam logic [63:0] IV_128A = 64'h80800c0800000000;

  // classified work item passed from front to back
  typedef struct packed {
    op_t         op;
    logic        last;
    logic [3:0]  n;
    logic [63:0] d0;
    logic [63:0] d1;
    logic [63:0] t0;
    logic [63:0] t1;
    logic        dom_sep;
  } cmd_t;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int k);
    rotr = (v >> k) | (v << (64 - k));
  endfunction

  function automatic logic [63:0] head_mask(input logic [3:0] n);
    logic [63:0] m;
    m = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[63 - 8*i -: 8] = 8'hff;
    end
    head_mask = m;
  endfunction

  function automatic logic [63:0] pad_word(input logic [2:0] n);
    pad_word = 64'h80 << (6'd56 - {n, 3'b000});
  endfunction

  function automatic logic [7:0] round_const(input logic [3:0] i);
    round_const = {4'hf - i, i};
  endfunction

  function automatic logic [319:0] one_round(input logic [319:0] s,
                                              input logic [7:0] c);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    {x0, x1, x2, x3, x4} = s;
    x2 = x2 ^ {56'd0, c};
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
    x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    x2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
    x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    x4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    one_round = {x0, x1, x2, x3, x4};
  endfunction

endpackage

>>> rtl/asc_front.sv
module asc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  input  logic [63:0]    data_high,
  input  logic [63:0]    data_low,
  input  logic [4:0]     byte_count,
  input  logic           last_block,
  input  logic [63:0]    tag_high,
  input  logic [63:0]    tag_low,
  output asc_pkg::cmd_t  q_data,
  output logic           q_valid,
  input  logic           q_ready
);
  import asc_pkg::*;

  localparam int DEPTH = 2;

  cmd_t   fifo [DEPTH];
  logic   wptr, rptr;
  logic [1:0] count;
  phase_t phase, phase_next;
  logic   push, pop, keep, dsep;
  cmd_t   cmd;
  logic [3:0] n_sat;

  assign in_ready = (count != 2'(DEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_data   = fifo[rptr];
  assign pop      = q_valid && q_ready;

  // classify against the tracked phase; drop ignored items here
  always_comb begin
    phase_next = phase;
    keep = 1'b0;
    dsep = 1'b0;
    case (op_t'(opcode))
      OP_START: begin
        keep = 1'b1;
        phase_next = PH_AD;
      end
      OP_AD: begin
        if (phase == PH_AD) begin
          keep = 1'b1;
          if (last_block) phase_next = PH_MSG;
        end
      end
      OP_MSG: begin
        if (phase != PH_IDLE) begin
          keep = 1'b1;
          dsep = (phase == PH_AD);
          phase_next = last_block ? PH_IDLE : PH_MSG;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign n_sat = (byte_count > 5'd15) ? 4'd15 : byte_count[3:0];
  assign push  = in_valid && in_ready && keep;

  always_comb begin
    cmd.op      = op_t'(opcode);
    cmd.last    = last_block;
    cmd.n       = last_block ? n_sat : 4'd0;
    cmd.d0      = data_high;
    cmd.d1      = data_low;
    cmd.t0      = tag_high;
    cmd.t1      = tag_low;
    cmd.dom_sep = dsep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) phase <= phase_next;
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= cmd;
  end

endmodule

>>> rtl/asc_back.sv
module asc_back (
  input  logic           clk,
  input  logic           rst,
  input  asc_pkg::cmd_t  q_data,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [63:0]    key_high,
  input  logic [63:0]    key_low,
  input  logic           decrypt_mode,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_high,
  output logic [63:0]    out_low,
  output logic [4:0]     out_bytes,
  output logic [1:0]     out_kind,
  output logic           out_last
);
  import asc_pkg::*;

  eng_state_t  state, state_next;
  logic [319:0] s, s_next;
  logic [3:0]  rnd, rnd_next;
  post_t       rend, rend_next;
  logic        fin, fin_next;
  logic [63:0] tg0, tg1;
  logic        take;
  logic        ld_out, ld_tag;
  logic [63:0] o0, o1;
  logic [63:0] x0, x1, x2, x3, x4, d0, d1, m0, m1;
  logic [63:0] c0, c1;
  logic [319:0] s_load;
  logic [3:0]  r_load;
  logic        f_load;
  post_t       p_load;

  // only a message block needs the output register free to start
  assign take = (state == ST_IDLE) && q_valid &&
                ((q_data.op != OP_MSG) || !out_valid || out_ready);
  assign q_ready = take;

  // absorb/decode datapath for the item at the queue head
  always_comb begin
    {x0, x1, x2, x3, x4} = s;
    if (q_data.dom_sep) x4 = x4 ^ 64'd1;
    m0 = q_data.last ? head_mask((q_data.n >= 4'd8) ? 4'd8 : q_data.n) : '1;
    m1 = q_data.last ? ((q_data.n > 4'd8) ? head_mask(q_data.n - 4'd8) : 64'd0) : '1;
    d0 = q_data.d0 & m0;
    d1 = q_data.d1 & m1;
    c0 = x0 ^ d0;
    c1 = x1 ^ d1;
    o0 = c0 & m0;
    o1 = c1 & m1;
    r_load = 4'd4;
    f_load = 1'b0;
    p_load = POST_NONE;
    s_load = s;
    case (q_data.op)
      OP_START: begin
        s_load = {IV_128A, key_high, key_low, q_data.d0, q_data.d1};
        r_load = 4'd0;
        p_load = POST_KEY;
      end
      OP_AD: begin
        x0 = c0; x1 = c1;
        if (q_data.last) begin
          if (q_data.n >= 4'd8) x1 = x1 ^ pad_word(3'(q_data.n - 4'd8));
          else x0 = x0 ^ pad_word(q_data.n[2:0]);
          p_load = POST_DSEP;
        end
        s_load = {x0, x1, x2, x3, x4};
      end
      OP_MSG: begin
        if (decrypt_mode) begin
          x0 = (x0 & ~m0) ^ d0;
          x1 = (x1 & ~m1) ^ d1;
        end else begin
          x0 = c0; x1 = c1;
        end
        if (q_data.last) begin
          if (q_data.n >= 4'd8) x1 = x1 ^ pad_word(3'(q_data.n - 4'd8));
          else x0 = x0 ^ pad_word(q_data.n[2:0]);
          x2 = x2 ^ key_high;
          x3 = x3 ^ key_low;
          r_load = 4'd0;
          f_load = 1'b1;
        end
        s_load = {x0, x1, x2, x3, x4};
      end
      default: s_load = s;
    endcase
  end

  // sequencer: one round per cycle, then post-processing
  always_comb begin
    state_next = state;
    s_next = s;
    rnd_next = rnd;
    rend_next = rend;
    fin_next = fin;
    ld_out = 1'b0;
    ld_tag = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          s_next = s_load;
          rnd_next = r_load;
          fin_next = f_load;
          rend_next = p_load;
          state_next = ST_RUN;
          ld_out = (q_data.op == OP_MSG);
        end
      end
      ST_RUN: begin
        s_next = one_round(s, round_const(rnd));
        rnd_next = rnd + 4'd1;
        if (rnd == 4'd11) begin
          state_next = ST_IDLE;
          if (fin) begin
            state_next = ST_TAG;
          end else if (rend == POST_KEY) begin
            s_next[127:0] = s_next[127:0] ^ {key_high, key_low};
          end else if (rend == POST_DSEP) begin
            s_next[63:0] = s_next[63:0] ^ 64'd1;
          end
        end
      end
      ST_TAG: begin
        s_next[127:0] = s[127:0] ^ {key_high, key_low};
        if (!out_valid || out_ready) begin
          ld_tag = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s <= '0;
      rnd <= 4'd0;
      rend <= POST_NONE;
      fin <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != ST_TAG) s <= s_next;
      else if (ld_tag) s <= s_next;
      rnd <= rnd_next;
      rend <= rend_next;
      fin <= fin_next;
      if (ld_out || ld_tag) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // output payload and saved received tag
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_high  <= decrypt_mode ? o0 : (x0 & m0);
      out_low   <= decrypt_mode ? o1 : (x1 & m1);
      out_bytes <= q_data.last ? {1'b0, q_data.n} : 5'd16;
      out_kind  <= KIND_DATA;
      out_last  <= 1'b0;
      tg0 <= q_data.t0;
      tg1 <= q_data.t1;
    end else if (ld_tag) begin
      if (decrypt_mode) begin
        out_high  <= 64'd0;
        out_low   <= 64'd0;
        out_bytes <= 5'd0;
        out_kind  <= (((s[127:64] ^ key_high ^ tg0) | (s[63:0] ^ key_low ^ tg1)) == 64'd0)
                     ? KIND_OK : KIND_BAD;
      end else begin
        out_high  <= s[127:64] ^ key_high;
        out_low   <= s[63:0] ^ key_low;
        out_bytes <= 5'd16;
        out_kind  <= KIND_TAG;
      end
      out_last <= 1'b1;
    end
  end

endmodule

>>> rtl/ascon128a_aead_engine.sv
// Channel | Signals                                         | Accepted when
// in      | in_valid/in_ready, opcode, data_*, byte_count,   | in_valid && in_ready
//         | last_block, tag_*                                |
// out     | out_valid/out_ready, out_high/low, bytes, kind,  | out_valid && out_ready
//         | out_last                                         |
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data         | cfg_valid && cfg_ready
// A block is loaded, then runs 8 rounds (12 for start or final) of the
// shared round unit; a last message block then forms its tag.
// A 2-entry queue decouples input from the round unit; the output register
// holds a result while the rounds run, and only a message block waits for
// a held result to drain before it starts. Reset is synchronous.
module ascon128a_aead_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  byte_count,
  input  logic        last_block,
  input  logic [63:0] tag_high,
  input  logic [63:0] tag_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic [4:0]  out_bytes,
  output logic [1:0]  out_kind,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import asc_pkg::*;

  cmd_t q_data;
  logic q_valid, q_ready;
  logic [63:0] key_high, key_low;
  logic decrypt_mode;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_HIGH: key_high <= cfg_data;
        CFG_KEY_LOW:  key_low <= cfg_data;
        CFG_DECRYPT:  decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .opcode, .data_high, .data_low,
    .byte_count, .last_block, .tag_high, .tag_low,
    .q_data, .q_valid, .q_ready
  );

  asc_back u_back (
    .clk, .rst, .q_data, .q_valid, .q_ready, .key_high, .key_low,
    .decrypt_mode, .out_valid, .out_ready, .out_high, .out_low,
    .out_bytes, .out_kind, .out_last
  );

endmodule

>>> tb/tb_ascon128a_aead_engine.sv
`timescale 1ns / 100ps

module tb_ascon128a_aead_engine;
  import asc_pkg::*;

  // one expected result
  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    kind_t       kind;
    logic        lst;
  } result_t;

  // Ascon-128a predictor plus queue of pending results
  class aead_scoreboard;
    logic [63:0] st [5];
    phase_t      ph;
    logic [63:0] key_hi, key_lo;
    logic        dec;
    result_t     pending [$];
    int          errors;

    function new();
      foreach (st[i]) st[i] = 64'd0;
      ph = PH_IDLE;
      key_hi = 64'd0;
      key_lo = 64'd0;
      dec = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] v);
      case (idx)
        CFG_KEY_HIGH: key_hi = v;
        CFG_KEY_LOW:  key_lo = v;
        CFG_DECRYPT:  dec = v[0];
        default: ;
      endcase
    endfunction

    static function logic [63:0] ror(logic [63:0] v, int k);
      return (v >> k) | (v << (64 - k));
    endfunction

    static function logic [63:0] first_bytes(int n);
      if (n <= 0) return 64'd0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
    endfunction

    static function logic [63:0] pad_at(int n);
      return 64'h80 << (56 - 8 * n);
    endfunction

    function void rounds(int count);
      logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
      logic [3:0] ci;
      for (int r = 0; r < count; r++) begin
        ci = 4'(12 - count + r);
        x0 = st[0]; x1 = st[1]; x2 = st[2]; x3 = st[3]; x4 = st[4];
        x2 ^= {56'd0, 4'hf - ci, ci};
        x0 ^= x4; x4 ^= x3; x2 ^= x1;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
        x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
        x0 ^= ror(x0, 19) ^ ror(x0, 28);
        x1 ^= ror(x1, 61) ^ ror(x1, 39);
        x2 ^= ror(x2, 1) ^ ror(x2, 6);
        x3 ^= ror(x3, 10) ^ ror(x3, 17);
        x4 ^= ror(x4, 7) ^ ror(x4, 41);
        st[0] = x0; st[1] = x1; st[2] = x2; st[3] = x3; st[4] = x4;
      end
    endfunction

    function void push(logic [63:0] h, logic [63:0] l, int nb, kind_t k, logic ls);
      result_t r;
      r.hi = h; r.lo = l; r.nbytes = 5'(nb); r.kind = k; r.lst = ls;
      pending.push_back(r);
    endfunction

    // note an accepted request and queue its results
    function void note_request(op_t op, logic [63:0] d0, logic [63:0] d1,
                               logic [4:0] cnt, logic lastb,
                               logic [63:0] th, logic [63:0] tl);
      int n;
      logic [63:0] m0, m1;
      n = (cnt > 15) ? 15 : int'(cnt);
      m0 = first_bytes(n);
      m1 = (n > 8) ? first_bytes(n - 8) : 64'd0;
      if (op == OP_START) begin
        st[0] = IV_128A; st[1] = key_hi; st[2] = key_lo; st[3] = d0; st[4] = d1;
        rounds(12);
        st[3] ^= key_hi; st[4] ^= key_lo;
        ph = PH_AD;
        return;
      end
      if (op == OP_AD) begin
        if (ph != PH_AD) return;
        if (!lastb) begin
          st[0] ^= d0; st[1] ^= d1;
          rounds(8);
          return;
        end
        st[0] ^= d0 & m0; st[1] ^= d1 & m1;
        if (n >= 8) st[1] ^= pad_at(n - 8); else st[0] ^= pad_at(n);
        rounds(8);
        st[4] ^= 64'd1;
        ph = PH_MSG;
        return;
      end
      if (op != OP_MSG || ph == PH_IDLE) return;
      // no closing AD block: domain separation without padding
      if (ph == PH_AD) begin
        st[4] ^= 64'd1;
        ph = PH_MSG;
      end
      if (!lastb) begin
        if (dec) begin
          push(st[0] ^ d0, st[1] ^ d1, 16, KIND_DATA, 1'b0);
          st[0] = d0; st[1] = d1;
        end else begin
          st[0] ^= d0; st[1] ^= d1;
          push(st[0], st[1], 16, KIND_DATA, 1'b0);
        end
        rounds(8);
        return;
      end
      d0 &= m0; d1 &= m1;
      if (dec) begin
        push((st[0] ^ d0) & m0, (st[1] ^ d1) & m1, n, KIND_DATA, 1'b0);
        st[0] = (st[0] & ~m0) ^ d0;
        st[1] = (st[1] & ~m1) ^ d1;
      end else begin
        st[0] ^= d0; st[1] ^= d1;
        push(st[0] & m0, st[1] & m1, n, KIND_DATA, 1'b0);
      end
      if (n >= 8) st[1] ^= pad_at(n - 8); else st[0] ^= pad_at(n);
      st[2] ^= key_hi; st[3] ^= key_lo;
      rounds(12);
      st[3] ^= key_hi; st[4] ^= key_lo;
      if (dec)
        push(64'd0, 64'd0, 0, (((st[3] ^ th) | (st[4] ^ tl)) == 64'd0) ? KIND_OK : KIND_BAD,
             1'b1);
      else
        push(st[3], st[4], 16, KIND_TAG, 1'b1);
      ph = PH_IDLE;
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h", what, got, want);
    endfunction

    function void check_result(logic [63:0] h, logic [63:0] l, logic [4:0] nb,
                               logic [1:0] k, logic ls);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", h, 64'd0);
        return;
      end
      e = pending.pop_front();
      if (h !== e.hi) report("out_high", h, e.hi);
      if (l !== e.lo) report("out_low", l, e.lo);
      if (nb !== e.nbytes) report("out_bytes", 64'(nb), 64'(e.nbytes));
      if (k !== e.kind) report("out_kind", 64'(k), 64'(e.kind));
      if (ls !== e.lst) report("out_last", 64'(ls), 64'(e.lst));
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  opcode;
  logic [63:0] data_high, data_low, tag_high, tag_low;
  logic [4:0]  byte_count;
  logic        last_block;
  logic        out_valid, out_ready;
  logic [63:0] out_high, out_low;
  logic [4:0]  out_bytes;
  logic [1:0]  out_kind;
  logic        out_last;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  aead_scoreboard sb;
  bit             calm;  // no idling in the closing stretch
  int             sent;

  ascon128a_aead_engine uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_ascon128a_aead_engine failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // receiver with random stall bursts
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(out_high, out_low, out_bytes, out_kind, out_last);
    end
  end

  // valid stays high into the next request unless an idle burst drops it
  task automatic send(op_t op, logic [63:0] d0, logic [63:0] d1, logic [4:0] cnt,
                      logic lastb, logic [63:0] th, logic [63:0] tl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    data_high  <= d0;
    data_low   <= d1;
    byte_count <= cnt;
    last_block <= lastb;
    tag_high   <= th;
    tag_low    <= tl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, d0, d1, cnt, lastb, th, tl);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // drain results, then cover the idle-tail of items that produce none
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_keys(logic [63:0] kh, logic [63:0] kl, logic d);
    settle();
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_KEY_LOW, kl);
    write_reg(CFG_DECRYPT, 64'(d));
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed messages, with some noise
  task automatic random_message(int nad, int nmsg, bit close_ad, bit good_tag);
    logic [4:0]  cnt;
    logic [63:0] d0, d1, th, tl;
    send(OP_START, rand64(), rand64(), 5'($urandom_range(0, 31)), $urandom_range(0, 1),
         rand64(), rand64());
    for (int i = 0; i < nad; i++)
      send(OP_AD, rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b0, rand64(), rand64());
    if (close_ad) begin
      cnt = 5'($urandom_range(0, 16));
      send(OP_AD, rand64(), rand64(), cnt, 1'b1, rand64(), rand64());
    end
    if ($urandom_range(0, 9) == 0)
      send(op_t'($urandom_range(0, 3) | 1), rand64(), rand64(), 5'($urandom_range(0, 31)),
           $urandom_range(0, 1), rand64(), rand64());
    for (int i = 0; i < nmsg; i++)
      send(OP_MSG, rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b0, rand64(), rand64());
    cnt = 5'($urandom_range(0, 16));
    d0 = rand64();
    d1 = rand64();
    th = rand64();
    tl = rand64();
    // a matching tag is predicted by running the model on a copy
    if (good_tag && sb.dec && sb.ph != PH_IDLE) begin
      aead_scoreboard cp;
      cp = new();
      cp.st = sb.st; cp.ph = sb.ph; cp.key_hi = sb.key_hi; cp.key_lo = sb.key_lo;
      cp.dec = sb.dec;
      cp.note_request(OP_MSG, d0, d1, cnt, 1'b1, th, tl);
      th = cp.st[3];
      tl = cp.st[4];
    end
    send(OP_MSG, d0, d1, cnt, 1'b1, th, tl);
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0; opcode = OP_START; data_high = '0; data_low = '0;
    byte_count = '0; last_block = 1'b0; tag_high = '0; tag_low = '0;
    cfg_valid = 1'b0; cfg_index = CFG_KEY_HIGH; cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wrong-phase noise while idle, then extremes
    send(OP_MSG, '1, '1, 5'd16, 1'b1, '0, '0);
    send(OP_AD, '1, '1, 5'd3, 1'b1, '0, '0);
    send(OP_NONE, '1, '1, 5'd31, 1'b1, '1, '1);
    set_keys('0, '0, 1'b0);
    send(OP_START, '0, '0, 5'd0, 1'b0, '0, '0);
    send(OP_AD, '1, '1, 5'd0, 1'b0, '0, '0);
    send(OP_AD, '1, '1, 5'd0, 1'b1, '0, '0);   // empty last AD block
    send(OP_MSG, '1, '1, 5'd5, 1'b0, '0, '0);
    send(OP_MSG, '1, '1, 5'd31, 1'b1, '0, '0); // oversized count saturates
    send(OP_START, '1, '1, 5'd0, 1'b0, '0, '0);
    send(OP_MSG, '1, 64'h0123456789abcdef, 5'd0, 1'b1, '0, '0); // no AD, empty last
    set_keys('1, '1, 1'b1);
    send(OP_START, 64'h5a5a, '1, 5'd0, 1'b0, '0, '0);
    send(OP_AD, '1, '0, 5'd16, 1'b0, '0, '0);  // full AD, no closing block
    send(OP_MSG, '1, '1, 5'd8, 1'b1, '1, '1);
    random_message(0, 0, 1'b1, 1'b1);
    send(OP_START, '0, '0, 5'd0, 1'b0, '0, '0);
    send(OP_START, '1, '0, 5'd0, 1'b0, '0, '0); // restart mid-message
    send(OP_AD, '0, '1, 5'd15, 1'b1, '0, '0);
    send(OP_AD, '0, '1, 5'd15, 1'b1, '0, '0);   // AD after AD phase: ignored
    send(OP_MSG, '0, '1, 5'd9, 1'b1, '0, '0);

    // random phases over several key and mode settings
    while (sent < 640) begin
      if ($urandom_range(0, 7) == 0)
        set_keys(rand64(), rand64(), $urandom_range(0, 1));
      if (sent > 580) calm = 1'b1;
      random_message($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 5) != 0,
                     $urandom_range(0, 1));
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_ascon128a_aead_engine passed");
    else
      $display("tb_ascon128a_aead_engine failed");
    $finish;
  end

endmodule
